>>> rtl/cus_pkg.sv
// Shared constants, field layout and status mapping for the CPU utilization sampler.
`default_nettype none

package cus_pkg;

    localparam int CNT_N     = 8;
    localparam int CNT_W     = 64;
    localparam int IDX_W     = 3;
    localparam int SUM_W     = 67;
    localparam int NUM_W     = 75;
    localparam int STAT_W    = 2;
    localparam int TIME_IN_W = 48;
    localparam int PCT_W     = 7;
    localparam int ERR_W     = 3;

    localparam int IDLE_IDX   = 3;
    localparam int IOWAIT_IDX = 4;

    localparam int S_TDATA_W = 568;
    localparam int S_STAT_LO = 512;
    localparam int S_TIME_LO = 514;

    localparam int M_TDATA_W = 112;

    localparam logic OP_SAMPLE  = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
    localparam logic [STAT_W-1:0] ST_MISSING    = 2'd1;
    localparam logic [STAT_W-1:0] ST_MALFORMED  = 2'd2;
    localparam logic [STAT_W-1:0] ST_UNREADABLE = 2'd3;

    localparam logic [ERR_W-1:0] ERR_NONE       = 3'd0;
    localparam logic [ERR_W-1:0] ERR_UNREADABLE = 3'd1;
    localparam logic [ERR_W-1:0] ERR_MISSING    = 3'd2;
    localparam logic [ERR_W-1:0] ERR_MALFORMED  = 3'd3;
    localparam logic [ERR_W-1:0] ERR_CNT_RESET  = 3'd4;

    localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

    function automatic logic [ERR_W-1:0] err_of_status(input logic [STAT_W-1:0] st);
        logic [ERR_W-1:0] e;
        unique case (st)
            ST_MISSING:   e = ERR_MISSING;
            ST_MALFORMED: e = ERR_MALFORMED;
            default:      e = ERR_UNREADABLE;
        endcase
        return e;
    endfunction

endpackage

`default_nettype wire

>>> rtl/cpu_utilization_sampler.sv
// Top level: CPU utilization sampler with counter memory, delta sweep and percent divider.
`default_nettype none

// Each accepted sample that yields a percentage passes through accept, the
// sweep through the counter memory, the error check, the S_MUL and S_ADD
// states that form the rounded numerator, the restoring divide and the post
// of the result; a restart or an error result skips the numerator and divide
// steps. The sweep is set by the single read and write port of the 8 x 64
// counter memory, one counter per cycle; the divide yields one quotient bit
// per cycle. A new sample is taken while the previous result still waits in
// the output register.
module cpu_utilization_sampler #(
    parameter int TIME_WIDTH = 48
) (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire                            s_tvalid,
    output logic                           s_tready,
    // user, nice, system, idle, iowait, irq, softirq, steal ticks (64 each),
    // sample_status (2), sample_time_ms (48), zero pad (6)
    input  wire  [cus_pkg::S_TDATA_W-1:0]  s_tdata,
    // opcode (1)
    input  wire                            s_tuser,
    output logic                           m_tvalid,
    input  wire                            m_tready,
    // available (1), percent (7), interval_ms (48), error_code (3),
    // failure_since_ms (48), zero pad (5)
    output logic [cus_pkg::M_TDATA_W-1:0]  m_tdata,
    // baseline_only (1)
    output logic                           m_tuser
);

    localparam int TW = (TIME_WIDTH < cus_pkg::TIME_IN_W) ? TIME_WIDTH : cus_pkg::TIME_IN_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SWEEP = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_ADD   = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0] state_reg, state_next;

    logic [cus_pkg::CNT_W-1:0]  mem [cus_pkg::CNT_N];
    logic [cus_pkg::CNT_N-1:0]  mem_vld_reg;
    logic [cus_pkg::CNT_W-1:0]  rd_data_reg;
    logic                       rd_vld_reg;
    logic [cus_pkg::IDX_W-1:0]  rd_addr;
    logic                       mem_we;

    logic [cus_pkg::CNT_W-1:0]  cur_reg [cus_pkg::CNT_N];
    logic                       op_reg;
    logic [cus_pkg::STAT_W-1:0] st_reg;
    logic [TW-1:0]              t_reg;

    logic [cus_pkg::IDX_W-1:0]  idx_reg;
    logic                       back_reg;
    logic [cus_pkg::SUM_W-1:0]  total_reg;
    logic [cus_pkg::SUM_W-1:0]  active_reg;
    logic [cus_pkg::NUM_W-1:0]  num_reg;
    logic [cus_pkg::NUM_W-1:0]  dv_reg;
    logic [cus_pkg::PCT_W-1:0]  q_reg;
    logic [2:0]                 step_reg;

    logic [cus_pkg::STAT_W-1:0] prev_status_reg;
    logic [TW-1:0]              prev_time_reg;
    logic [cus_pkg::ERR_W-1:0]  fail_code_reg;
    logic [TW-1:0]              fail_since_reg;

    logic                       m_tvalid_reg;
    logic [cus_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic                       m_tuser_reg;

    logic                       accept;
    logic                       post;
    logic [cus_pkg::CNT_W-1:0]  prev_cnt;
    logic [cus_pkg::CNT_W-1:0]  cur_cnt;
    logic [cus_pkg::CNT_W-1:0]  delta;
    logic                       busy_idx;
    logic                       total_zero;
    logic                       can_divide;
    logic [cus_pkg::ERR_W-1:0]  err;
    logic [TW-1:0]              win;
    logic [TW-1:0]              since_out;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign post     = (state_reg == S_DONE) && (!m_tvalid_reg || m_tready);

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    assign prev_cnt = rd_vld_reg ? rd_data_reg : '0;
    assign cur_cnt  = cur_reg[idx_reg];
    assign delta    = cur_cnt - prev_cnt;
    assign busy_idx = (idx_reg != cus_pkg::IDX_W'(cus_pkg::IDLE_IDX)) &&
                      (idx_reg != cus_pkg::IDX_W'(cus_pkg::IOWAIT_IDX));
    assign total_zero = (total_reg == '0);

    always_comb begin
        priority if (prev_status_reg != cus_pkg::ST_OK) begin
            err = cus_pkg::err_of_status(prev_status_reg);
        end else if (st_reg != cus_pkg::ST_OK) begin
            err = cus_pkg::err_of_status(st_reg);
        end else if (back_reg) begin
            err = cus_pkg::ERR_CNT_RESET;
        end else if (total_zero) begin
            err = cus_pkg::ERR_MALFORMED;
        end else begin
            err = cus_pkg::ERR_NONE;
        end
    end

    assign can_divide = (op_reg == cus_pkg::OP_SAMPLE) && (err == cus_pkg::ERR_NONE);
    assign win        = t_reg - prev_time_reg;
    assign since_out  = (fail_code_reg != err) ? t_reg : fail_since_reg;

    assign rd_addr = (state_reg == S_SWEEP) ? (idx_reg + 1'b1) : '0;
    assign mem_we  = (state_reg == S_SWEEP);

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[idx_reg] <= cur_cnt;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mem_vld_reg <= '0;
            rd_vld_reg  <= 1'b0;
        end else begin
            if (mem_we) begin
                mem_vld_reg[idx_reg] <= 1'b1;
            end
            rd_vld_reg <= mem_vld_reg[rd_addr];
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (accept) state_next = S_SWEEP;
            S_SWEEP: if (idx_reg == '1) state_next = S_DONE;
            S_MUL:   state_next = S_ADD;
            S_ADD:   state_next = S_DIV;
            S_DIV:   if (step_reg == 3'd6) state_next = S_DONE;
            S_DONE:  if (post) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
        if (state_reg == S_DONE && step_reg == 3'd0 && can_divide) begin
            state_next = S_MUL;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    for (int i = 0; i < cus_pkg::CNT_N; i++) begin
                        cur_reg[i] <= s_tdata[i*cus_pkg::CNT_W +: cus_pkg::CNT_W];
                    end
                    op_reg     <= s_tuser;
                    st_reg     <= s_tdata[cus_pkg::S_STAT_LO +: cus_pkg::STAT_W];
                    t_reg      <= s_tdata[cus_pkg::S_TIME_LO +: TW];
                    idx_reg    <= '0;
                    back_reg   <= 1'b0;
                    total_reg  <= '0;
                    active_reg <= '0;
                    q_reg      <= '0;
                    step_reg   <= '0;
                end
            end
            S_SWEEP: begin
                idx_reg   <= idx_reg + 1'b1;
                if (cur_cnt < prev_cnt) begin
                    back_reg <= 1'b1;
                end
                total_reg <= total_reg + cus_pkg::SUM_W'(delta);
                if (busy_idx) begin
                    active_reg <= active_reg + cus_pkg::SUM_W'(delta);
                end
            end
            S_MUL: begin
                num_reg <= cus_pkg::NUM_W'({active_reg, 7'b0}) +
                           cus_pkg::NUM_W'({active_reg, 6'b0}) +
                           cus_pkg::NUM_W'({active_reg, 3'b0});
            end
            S_ADD: begin
                num_reg <= num_reg + cus_pkg::NUM_W'(total_reg);
                dv_reg  <= cus_pkg::NUM_W'({total_reg, 7'b0});
            end
            S_DIV: begin
                if (num_reg >= dv_reg) begin
                    num_reg <= num_reg - dv_reg;
                    q_reg   <= {q_reg[cus_pkg::PCT_W-2:0], 1'b1};
                end else begin
                    q_reg   <= {q_reg[cus_pkg::PCT_W-2:0], 1'b0};
                end
                dv_reg   <= dv_reg >> 1;
                step_reg <= step_reg + 1'b1;
            end
            S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_status_reg <= cus_pkg::ST_UNREADABLE;
            prev_time_reg   <= '0;
            fail_code_reg   <= cus_pkg::ERR_NONE;
            fail_since_reg  <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            if (post && !(step_reg == 3'd0 && can_divide)) begin
                m_tvalid_reg    <= 1'b1;
                prev_status_reg <= st_reg;
                prev_time_reg   <= t_reg;
                if (op_reg == cus_pkg::OP_RESTART) begin
                    fail_code_reg <= cus_pkg::ERR_NONE;
                end else if (err == cus_pkg::ERR_NONE) begin
                    fail_code_reg <= cus_pkg::ERR_NONE;
                end else if (fail_code_reg != err) begin
                    fail_code_reg  <= err;
                    fail_since_reg <= t_reg;
                end
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (post && !(step_reg == 3'd0 && can_divide)) begin
            if (op_reg == cus_pkg::OP_RESTART) begin
                m_tuser_reg <= 1'b1;
                m_tdata_reg <= '0;
            end else begin
                m_tuser_reg <= 1'b0;
                m_tdata_reg <= {
                    5'b0,
                    (err == cus_pkg::ERR_NONE) ? 48'd0 : 48'(since_out),
                    err,
                    48'(win),
                    q_reg,
                    (err == cus_pkg::ERR_NONE)
                };
            end
        end
    end

    a_restart_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("restart result carries nonzero fields");

    a_avail_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser && m_tdata[0]) |->
        (m_tdata[58:56] == cus_pkg::ERR_NONE && m_tdata[106:59] == '0))
        else $error("available result carries an error or failure time");

    a_pct_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[7:1] <= cus_pkg::PCT_MAX))
        else $error("percent above maximum");

    a_err_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser && !m_tdata[0]) |->
        (m_tdata[58:56] != cus_pkg::ERR_NONE && m_tdata[7:1] == '0))
        else $error("unavailable result without error code");

    a_sweep_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SWEEP && idx_reg == '1) |=> (mem_vld_reg == '1))
        else $error("counter memory not fully written after sweep");

endmodule

`default_nettype wire

>>> tb/tb_cpu_utilization_sampler.sv
// Testbench for cpu_utilization_sampler: directed and random samples checked against a predictor.
`default_nettype none

module tb_cpu_utilization_sampler;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                          baseline_only;
        logic                          available;
        logic [cus_pkg::PCT_W-1:0]     percent;
        logic [cus_pkg::TIME_IN_W-1:0] interval_ms;
        logic [cus_pkg::ERR_W-1:0]     error_code;
        logic [cus_pkg::TIME_IN_W-1:0] failure_since_ms;
    } util_result_t;

    class sample_scoreboard;
        logic [cus_pkg::CNT_W-1:0]     last_ticks [cus_pkg::CNT_N];
        logic [cus_pkg::STAT_W-1:0]    last_status;
        logic [cus_pkg::TIME_IN_W-1:0] last_time;
        logic [cus_pkg::ERR_W-1:0]     fail_code;
        logic [cus_pkg::TIME_IN_W-1:0] fail_since;
        util_result_t                  expected_q [$];
        int                            mismatches;

        function new();
            foreach (last_ticks[i]) last_ticks[i] = '0;
            last_status = cus_pkg::ST_UNREADABLE;
            last_time   = '0;
            fail_code   = cus_pkg::ERR_NONE;
            fail_since  = '0;
            mismatches  = 0;
        endfunction

        function logic [cus_pkg::ERR_W-1:0] status_error(logic [cus_pkg::STAT_W-1:0] st);
            case (st)
                cus_pkg::ST_MISSING:   return cus_pkg::ERR_MISSING;
                cus_pkg::ST_MALFORMED: return cus_pkg::ERR_MALFORMED;
                default:               return cus_pkg::ERR_UNREADABLE;
            endcase
        endfunction

        function void note_input(logic [cus_pkg::S_TDATA_W-1:0] tdata, logic opcode);
            logic [cus_pkg::CNT_W-1:0]     ticks [cus_pkg::CNT_N];
            logic [cus_pkg::CNT_W-1:0]     delta;
            logic [cus_pkg::STAT_W-1:0]    status;
            logic [cus_pkg::TIME_IN_W-1:0] stamp;
            logic [79:0]                   busy;
            logic [79:0]                   total;
            logic [cus_pkg::ERR_W-1:0]     err;
            util_result_t                  r;
            foreach (ticks[i]) ticks[i] = tdata[i*cus_pkg::CNT_W +: cus_pkg::CNT_W];
            status = tdata[cus_pkg::S_STAT_LO +: cus_pkg::STAT_W];
            stamp  = tdata[cus_pkg::S_TIME_LO +: cus_pkg::TIME_IN_W];
            r      = '0;
            if (opcode == cus_pkg::OP_RESTART) begin
                r.baseline_only = 1'b1;
                fail_code = cus_pkg::ERR_NONE;
            end else begin
                r.interval_ms = stamp - last_time;
                err   = cus_pkg::ERR_NONE;
                busy  = '0;
                total = '0;
                if (last_status != cus_pkg::ST_OK) begin
                    err = status_error(last_status);
                end else if (status != cus_pkg::ST_OK) begin
                    err = status_error(status);
                end else begin
                    foreach (ticks[i]) begin
                        if (ticks[i] < last_ticks[i]) err = cus_pkg::ERR_CNT_RESET;
                        delta = ticks[i] - last_ticks[i];
                        total = total + delta;
                        if (i != cus_pkg::IDLE_IDX && i != cus_pkg::IOWAIT_IDX)
                            busy = busy + delta;
                    end
                    if (err == cus_pkg::ERR_NONE && total == 0) begin
                        err = cus_pkg::ERR_MALFORMED;
                    end else if (err == cus_pkg::ERR_NONE) begin
                        r.percent = cus_pkg::PCT_W'((busy * 200 + total) / (total * 2));
                    end
                end
                if (err == cus_pkg::ERR_NONE) begin
                    fail_code   = cus_pkg::ERR_NONE;
                    r.available = 1'b1;
                end else begin
                    if (fail_code != err) begin
                        fail_code  = err;
                        fail_since = stamp;
                    end
                    r.failure_since_ms = fail_since;
                end
                r.error_code = err;
            end
            last_ticks  = ticks;
            last_status = status;
            last_time   = stamp;
            expected_q.push_back(r);
        endfunction

        function void check_field(string name, logic [cus_pkg::TIME_IN_W-1:0] want,
                                  logic [cus_pkg::TIME_IN_W-1:0] got);
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch in %s at %0t: expected %0h, got %0h",
                             name, $realtime, want, got);
            end
        endfunction

        function void check_result(logic [cus_pkg::M_TDATA_W-1:0] tdata, logic tuser);
            util_result_t got;
            util_result_t want;
            got.baseline_only    = tuser;
            got.available        = tdata[0];
            got.percent          = tdata[7:1];
            got.interval_ms      = tdata[55:8];
            got.error_code       = tdata[58:56];
            got.failure_since_ms = tdata[106:59];
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result with nothing pending at %0t: tuser %0b tdata %0h",
                             $realtime, tuser, tdata);
                return;
            end
            want = expected_q.pop_front();
            check_field("baseline_only", want.baseline_only, got.baseline_only);
            check_field("available", want.available, got.available);
            check_field("percent", want.percent, got.percent);
            check_field("interval_ms", want.interval_ms, got.interval_ms);
            check_field("error_code", want.error_code, got.error_code);
            check_field("failure_since_ms", want.failure_since_ms, got.failure_since_ms);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                            aclk     = 1'b0;
    logic                            aresetn  = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [cus_pkg::S_TDATA_W-1:0]   s_tdata  = '0;
    logic                            s_tuser  = 1'b0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b1;
    logic [cus_pkg::M_TDATA_W-1:0]   m_tdata;
    logic                            m_tuser;

    sample_scoreboard                sb = new();
    logic [cus_pkg::CNT_W-1:0]       ticks [cus_pkg::CNT_N];
    logic [cus_pkg::STAT_W-1:0]      status;
    logic [cus_pkg::TIME_IN_W-1:0]   stamp;
    int                              items_sent = 0;
    bit                              gaps_on    = 1'b1;
    int unsigned                     rx_hold    = 0;

    cpu_utilization_sampler u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.note_input(s_tdata, s_tuser);
            if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
        end
    end

    // hold off the result channel in random bursts
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b1;
            rx_hold  <= 0;
        end else if (rx_hold != 0) begin
            rx_hold <= rx_hold - 1;
            if (rx_hold == 1) m_tready <= 1'b1;
        end else if (gaps_on && $urandom_range(0, 4) == 0) begin
            m_tready <= 1'b0;
            rx_hold  <= $urandom_range(1, 8);
        end
    end

    function automatic logic [cus_pkg::CNT_W-1:0] rand_ticks();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [cus_pkg::TIME_IN_W-1:0] rand_stamp();
        logic [31:0] upper;
        upper = $urandom;
        return {upper[15:0], $urandom};
    endfunction

    function automatic logic [cus_pkg::CNT_W-1:0] tick_delta(int scale);
        case (scale)
            0:       return '0;
            6, 7:    return cus_pkg::CNT_W'($urandom_range(0, 1 << 20));
            8:       return cus_pkg::CNT_W'($urandom);
            9:       return rand_ticks() >> $urandom_range(0, 8);
            default: return cus_pkg::CNT_W'($urandom_range(0, 100));
        endcase
    endfunction

    task automatic set_all(input logic [cus_pkg::CNT_W-1:0] v);
        foreach (ticks[i]) ticks[i] = v;
    endtask

    task automatic push_sample(input logic opcode);
        logic [cus_pkg::S_TDATA_W-1:0] word;
        word = '0;
        foreach (ticks[i]) word[i*cus_pkg::CNT_W +: cus_pkg::CNT_W] = ticks[i];
        word[cus_pkg::S_STAT_LO +: cus_pkg::STAT_W]    = status;
        word[cus_pkg::S_TIME_LO +: cus_pkg::TIME_IN_W] = stamp;
        gaps_on = (items_sent < 1500) && ((items_sent / 150) % 4 != 3);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= opcode;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic step(input logic opcode, input logic [cus_pkg::STAT_W-1:0] st,
                        input logic [cus_pkg::TIME_IN_W-1:0] dt);
        status = st;
        stamp  = stamp + dt;
        push_sample(opcode);
    endtask

    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        int run_len;
        int scale;
        set_all('0);
        status = cus_pkg::ST_OK;
        stamp  = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // sample with no baseline yet, then a clean baseline
        step(cus_pkg::OP_SAMPLE, cus_pkg::ST_OK, 1000);
        step(cus_pkg::OP_RESTART, cus_pkg::ST_OK, 1000);
        step(cus_pkg::OP_SAMPLE, cus_pkg::ST_OK, 1000);
        step(cus_pkg::OP_SAMPLE, cus_pkg::ST_OK, 1000);
        ticks[0] += 1; ticks[cus_pkg::IDLE_IDX] += 199;
        step(cus_pkg::OP_SAMPLE, cus_pkg::ST_OK, 1000);
        ticks[0] += 1; ticks[cus_pkg::IDLE_IDX] += 201;
        step(cus_pkg::OP_SAMPLE, cus_pkg::ST_OK, 1000);
        ticks[0] += 5; ticks[1] += 1; ticks[2] += 1;
        ticks[5] += 1; ticks[6] += 1; ticks[7] += 1;
        step(cus_pkg::OP_SAMPLE, cus_pkg::ST_OK, 1000);
        ticks[0] += 1; ticks[cus_pkg::IOWAIT_IDX] += 1;
        step(cus_pkg::OP_SAMPLE, cus_pkg::ST_OK, 1000);
        // status precedence
        ticks[0] += 3;
        step(cus_pkg::OP_SAMPLE, cus_pkg::ST_MISSING, 1000);
        step(cus_pkg::OP_SAMPLE, cus_pkg::ST_OK, 1000);
        step(cus_pkg::OP_SAMPLE, cus_pkg::ST_MALFORMED, 1000);
        step(cus_pkg::OP_SAMPLE, cus_pkg::ST_UNREADABLE, 1000);
        step(cus_pkg::OP_SAMPLE, cus_pkg::ST_OK, 1000);
        ticks[7] -= 1;
        step(cus_pkg::OP_SAMPLE, cus_pkg::ST_OK, 1000);
        ticks[7] += 3; ticks[cus_pkg::IDLE_IDX] += 3;
        step(cus_pkg::OP_SAMPLE, cus_pkg::ST_OK, 1000);
        // time wrap around the top of the range
        stamp = '1;
        ticks[0] += 1;
        step(cus_pkg::OP_SAMPLE, cus_pkg::ST_OK, 0);
        ticks[0] += 1;
        step(cus_pkg::OP_SAMPLE, cus_pkg::ST_OK, 32);
        step(cus_pkg::OP_RESTART, cus_pkg::ST_UNREADABLE, 5);
        step(cus_pkg::OP_SAMPLE, cus_pkg::ST_OK, 5);
        // widest deltas and a full counter reset
        set_all('0);
        step(cus_pkg::OP_RESTART, cus_pkg::ST_OK, 5);
        set_all('1);
        step(cus_pkg::OP_SAMPLE, cus_pkg::ST_OK, 5);
        step(cus_pkg::OP_RESTART, cus_pkg::ST_OK, 5);
        set_all('0);
        step(cus_pkg::OP_SAMPLE, cus_pkg::ST_OK, 5);
        step(cus_pkg::OP_RESTART, cus_pkg::ST_OK, 5);
        ticks[cus_pkg::IDLE_IDX] = '1; ticks[cus_pkg::IOWAIT_IDX] = '1;
        step(cus_pkg::OP_SAMPLE, cus_pkg::ST_OK, 5);

        while (items_sent < 1800) begin
            if ($urandom_range(0, 9) == 0) begin
                foreach (ticks[i]) ticks[i] = rand_ticks();
                status = cus_pkg::STAT_W'($urandom_range(0, 3));
                stamp  = rand_stamp();
                push_sample(1'($urandom_range(0, 1)));
            end else begin
                case ($urandom_range(0, 2))
                    0:       foreach (ticks[i]) ticks[i] = rand_ticks();
                    1:       foreach (ticks[i])
                                 ticks[i] = cus_pkg::CNT_W'($urandom_range(0, 1000));
                    default: foreach (ticks[i]) ticks[i] = '1 - $urandom_range(0, 1 << 20);
                endcase
                status = ($urandom_range(0, 7) == 0) ?
                         cus_pkg::STAT_W'($urandom_range(1, 3)) : cus_pkg::ST_OK;
                stamp  = rand_stamp();
                push_sample(cus_pkg::OP_RESTART);
                run_len = $urandom_range(2, 12);
                repeat (run_len) begin
                    scale = $urandom_range(0, 9);
                    foreach (ticks[i]) ticks[i] += tick_delta(scale);
                    if ($urandom_range(0, 19) == 0)
                        ticks[$urandom_range(0, cus_pkg::CNT_N - 1)] -= 1 + $urandom_range(0, 99);
                    status = ($urandom_range(0, 11) == 0) ?
                             cus_pkg::STAT_W'($urandom_range(1, 3)) : cus_pkg::ST_OK;
                    stamp += ($urandom_range(0, 19) == 0) ? rand_stamp()
                             : cus_pkg::TIME_IN_W'($urandom_range(900, 2100));
                    push_sample(cus_pkg::OP_SAMPLE);
                end
            end
        end
        s_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire
